// File: rtl/kvi_pkg.sv
// Shared types and constants for the keyframe vector interpolator.
`timescale 1ns / 1ps

package kvi_pkg;

    // Table geometry.
    localparam int MAX_KEYS  = 64;
    localparam int ADDR_W    = $clog2(MAX_KEYS);
    localparam int SLOT_W    = 6;
    localparam int COUNT_W   = 7;
    localparam int KEY_LIMIT = (MAX_KEYS < 64) ? MAX_KEYS : 64;

    // Number formats.
    localparam int TIME_W   = 32;
    localparam int COMP_W   = 32;
    localparam int VEC_W    = 3 * COMP_W;
    localparam int FRAC_W   = 16;
    localparam int FACTOR_W = FRAC_W + 1;
    localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1) << FRAC_W;

    // Stream payload widths.
    localparam int S_DATA_W = 168;
    localparam int M_DATA_W = 104;
    localparam int M_USER_W = 2;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_kvi_op;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FEW   = 2'd1,
        STATUS_NONE  = 2'd2,
        STATUS_WRITE = 2'd3
    } t_kvi_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD_LO,
        ST_RD_HI,
        ST_LATCH,
        ST_FACTOR,
        ST_DIV,
        ST_BLEND,
        ST_DONE
    } t_kvi_state;

    // Keyframe write request into the key store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] key_tm;
        logic [VEC_W-1:0]  vec;
    } t_kvi_wr;

endpackage

// File: rtl/kvi_key_store.sv
// Keyframe time and vector memories with one write port and one registered read port.
`timescale 1ns / 1ps

module kvi_key_store (
    input  logic                          i_clk,
    input  kvi_pkg::t_kvi_wr              i_wr,
    input  logic [kvi_pkg::ADDR_W-1:0]    i_rd_addr,
    output logic [kvi_pkg::TIME_W-1:0]    o_rd_time,
    output logic [kvi_pkg::VEC_W-1:0]     o_rd_vec
);
    import kvi_pkg::*;

    logic [TIME_W-1:0] r_time_mem [MAX_KEYS];
    logic [VEC_W-1:0]  r_vec_mem  [MAX_KEYS];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_time_mem[i_wr.addr] <= i_wr.key_tm;
            r_vec_mem[i_wr.addr]  <= i_wr.vec;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rd_time <= r_time_mem[i_rd_addr];
        o_rd_vec  <= r_vec_mem[i_rd_addr];
    end

endmodule

// File: rtl/kvi_divider.sv
// Restoring divider that forms the 16-bit blend fraction one quotient bit per cycle.
`timescale 1ns / 1ps

module kvi_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [kvi_pkg::TIME_W-1:0]   i_dist,
    input  logic [kvi_pkg::TIME_W-1:0]   i_span,
    output logic                         o_done,
    output logic [kvi_pkg::FRAC_W-1:0]   o_quot
);
    import kvi_pkg::*;

    localparam int CNT_W = $clog2(FRAC_W + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_span;
    logic [FRAC_W-1:0] r_quot;
    logic              r_done;

    logic [TIME_W:0]   rem_sh;
    logic              fits;
    logic [TIME_W:0]   rem_sub;

    // One restoring step: shift the remainder left and try the subtract.
    always_comb begin
        rem_sh  = {r_rem, 1'b0};
        fits    = rem_sh >= {1'b0, r_span};
        rem_sub = rem_sh - {1'b0, r_span};
    end

    // Control: the start clears the count, the last step raises done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FRAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the distance is below the span, so the quotient fits in the fraction bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dist;
            r_span <= i_span;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
            r_quot <= {r_quot[FRAC_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: rtl/kvi_lerp_unit.sv
// Shared multiplier that blends the three vector components one after another.
`timescale 1ns / 1ps

module kvi_lerp_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [kvi_pkg::VEC_W-1:0]      i_v0,
    input  logic [kvi_pkg::VEC_W-1:0]      i_v1,
    input  logic [kvi_pkg::FACTOR_W-1:0]   i_factor,
    output logic                           o_done,
    output logic [kvi_pkg::VEC_W-1:0]      o_vec
);
    import kvi_pkg::*;

    localparam int PROD_W = COMP_W + 1 + FACTOR_W + 1;
    localparam int SUM_W  = PROD_W - FRAC_W + 1;
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sh8000_0000);

    logic                     r_busy;
    logic                     r_add_phase;
    logic [1:0]               r_comp;
    logic signed [PROD_W-1:0] r_prod;
    logic [VEC_W-1:0]         r_res;
    logic                     r_done;

    logic signed [COMP_W-1:0] comp_a;
    logic signed [COMP_W-1:0] comp_b;
    logic signed [COMP_W:0]   diff;
    logic signed [FACTOR_W:0] factor_s;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [SUM_W-1:0]  sum;
    logic [COMP_W-1:0]        sat;

    // Component select and the product term for the current component.
    always_comb begin
        comp_a   = i_v0[r_comp*COMP_W +: COMP_W];
        comp_b   = i_v1[r_comp*COMP_W +: COMP_W];
        diff     = {comp_b[COMP_W-1], comp_b} - {comp_a[COMP_W-1], comp_a};
        factor_s = {1'b0, i_factor};
        n_prod   = diff * factor_s;
    end

    // Floor by the arithmetic shift, add the earlier key, then saturate.
    always_comb begin
        prod_sh = r_prod >>> FRAC_W;
        sum     = prod_sh[SUM_W-1:0] + {{(SUM_W - COMP_W){comp_a[COMP_W-1]}}, comp_a};
        if (sum > SAT_MAX) begin
            sat = SAT_MAX[COMP_W-1:0];
        end else if (sum < SAT_MIN) begin
            sat = SAT_MIN[COMP_W-1:0];
        end else begin
            sat = sum[COMP_W-1:0];
        end
    end

    // Sequencing: multiply, then add, for each of the three components.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_add_phase <= 1'b0;
            r_comp      <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy      <= 1'b1;
                r_add_phase <= 1'b0;
                r_comp      <= '0;
            end else if (r_busy) begin
                r_add_phase <= !r_add_phase;
                if (r_add_phase) begin
                    r_comp <= r_comp + 1'b1;
                    if (r_comp == 2'd2) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // Product register and result vector.
    always_ff @(posedge i_clk) begin
        if (r_busy && !r_add_phase) begin
            r_prod <= n_prod;
        end
        if (r_busy && r_add_phase) begin
            r_res[r_comp*COMP_W +: COMP_W] <= sat;
        end
    end

    assign o_done = r_done;
    assign o_vec  = r_res;

endmodule

// File: rtl/keyframe_vector_interpolator_unit.sv
// Top level of the keyframe vector interpolator: sequencer, key table and output register.
//
//  Channel  | Direction | Contents
//  ---------+-----------+----------------------------------------------------------
//  s_axis   | in        | keyframe write or query, opcode in tuser
//  m_axis   | out       | blended vector, segment, status in tuser
//  cfg      | in        | key_count register write
//
// A query scans the key times, one key time read per cycle from the single memory read port
// for up to 63 keys, then runs the 16-bit restoring divider only when the blend fraction
// needs a division; the three components share one multiplier, a multiply step then an
// add step each.
// Reset is synchronous and active low; the key memories are not cleared.
// s_axis_tready is high only while the sequencer is idle; a finished result waits in the
// output register while the next transaction is accepted.
`timescale 1ns / 1ps

module keyframe_vector_interpolator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration: key_count.
    input  logic                              i_cfg_wr_en,
    input  logic [kvi_pkg::COUNT_W-1:0]       i_cfg_wr_data,
    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: key_slot, key_time, key_x, key_y, key_z, query_time, zero pad.
    input  logic [kvi_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // tuser: opcode.
    input  logic [0:0]                        s_axis_tuser,
    // Output stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: out_x, out_y, out_z, segment, zero pad.
    output logic [kvi_pkg::M_DATA_W-1:0]      m_axis_tdata,
    // tuser: status.
    output logic [kvi_pkg::M_USER_W-1:0]      m_axis_tuser
);
    import kvi_pkg::*;

    localparam logic [COUNT_W-1:0] LIMIT_C = COUNT_W'(KEY_LIMIT);

    // Input field unpacking.
    logic [SLOT_W-1:0] in_slot;
    logic [TIME_W-1:0] in_key_time;
    logic [VEC_W-1:0]  in_key_vec;
    logic [TIME_W-1:0] in_query;
    t_kvi_op           in_op;

    assign in_slot     = s_axis_tdata[SLOT_W-1:0];
    assign in_key_time = s_axis_tdata[SLOT_W +: TIME_W];
    assign in_key_vec  = s_axis_tdata[SLOT_W + TIME_W +: VEC_W];
    assign in_query    = s_axis_tdata[SLOT_W + TIME_W + VEC_W +: TIME_W];
    assign in_op       = t_kvi_op'(s_axis_tuser[0]);

    t_kvi_state r_state;
    t_kvi_state n_state;

    logic [COUNT_W-1:0] r_key_count;
    logic [TIME_W-1:0]  r_query;
    logic [ADDR_W-1:0]  r_idx;
    logic [ADDR_W-1:0]  r_cmp_i;
    logic               r_cmp_vld;
    logic [ADDR_W-1:0]  r_seg;
    t_kvi_status        r_status;
    logic [TIME_W-1:0]  r_t0;
    logic [TIME_W-1:0]  r_t1;
    logic [VEC_W-1:0]   r_v0;
    logic [VEC_W-1:0]   r_v1;
    logic [FACTOR_W-1:0] r_factor;
    logic [VEC_W-1:0]   r_res_vec;
    logic               r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    logic [M_USER_W-1:0] r_out_user;

    logic               in_accept;
    logic [COUNT_W-1:0] n_use;
    t_kvi_wr            wr_req;
    logic [ADDR_W-1:0]  rd_addr;
    logic [TIME_W-1:0]  rd_time;
    logic [VEC_W-1:0]   rd_vec;
    logic               cmp_hit;
    logic               cmp_end;
    logic               q_lt_t0;
    logic               sat_one;
    logic               need_div;
    logic [TIME_W-1:0]  q_delta;
    logic [TIME_W-1:0]  span;
    logic               div_start;
    logic               div_done;
    logic [FRAC_W-1:0]  div_quot;
    logic               lerp_start;
    logic               lerp_done;
    logic [VEC_W-1:0]   lerp_vec;
    logic               out_load;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign n_use     = (r_key_count > LIMIT_C) ? LIMIT_C : r_key_count;

    // Keyframe writes go straight to the table in the accepting cycle.
    always_comb begin
        wr_req.en     = in_accept && (in_op == OP_WRITE) && (int'(in_slot) < MAX_KEYS);
        wr_req.addr   = ADDR_W'(in_slot);
        wr_req.key_tm = in_key_time;
        wr_req.vec    = in_key_vec;
    end

    kvi_key_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr_req),
        .i_rd_addr (rd_addr),
        .o_rd_time (rd_time),
        .o_rd_vec  (rd_vec)
    );

    // Scan compare on the key time read in the previous cycle.
    assign cmp_hit = r_cmp_vld && (rd_time > r_query);
    assign cmp_end = r_cmp_vld && ({1'b0, r_cmp_i} == n_use - COUNT_W'(2));

    // Blend factor cases that need no division, and the flag for those that do.
    always_comb begin
        q_lt_t0  = r_query < r_t0;
        q_delta  = r_query - r_t0;
        span     = r_t1 - r_t0;
        sat_one  = (r_t1 <= r_t0) || (q_delta >= span);
        need_div = !q_lt_t0 && !sat_one;
    end

    kvi_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dist  (q_delta),
        .i_span  (span),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    kvi_lerp_unit u_lerp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (lerp_start),
        .i_v0     (r_v0),
        .i_v1     (r_v1),
        .i_factor (r_factor),
        .o_done   (lerp_done),
        .o_vec    (lerp_vec)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (in_op == OP_WRITE) begin
                        n_state = ST_DONE;
                    end else if (n_use < COUNT_W'(2)) begin
                        n_state = ST_RD_LO;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (cmp_hit || cmp_end) begin
                    n_state = ST_RD_LO;
                end
            end
            ST_RD_LO:  n_state = ST_RD_HI;
            ST_RD_HI:  n_state = ST_LATCH;
            ST_LATCH:  n_state = (r_status == STATUS_FEW) ? ST_DONE : ST_FACTOR;
            ST_FACTOR: n_state = need_div ? ST_DIV : ST_BLEND;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_BLEND;
                end
            end
            ST_BLEND: begin
                if (lerp_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        rd_addr       = r_seg;
        div_start     = 1'b0;
        lerp_start    = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_SCAN:   rd_addr = r_idx + 1'b1;
            ST_RD_LO:  rd_addr = r_seg;
            ST_RD_HI:  rd_addr = r_seg + 1'b1;
            ST_LATCH:  rd_addr = r_seg;
            ST_FACTOR: begin
                div_start  = need_div;
                lerp_start = !need_div;
            end
            ST_DIV:    lerp_start = div_done;
            ST_BLEND:  rd_addr = r_seg;
            ST_DONE:   out_load = !r_out_valid || m_axis_tready;
            default:   rd_addr = r_seg;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_key_count <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_key_count <= i_cfg_wr_data;
            end
            r_cmp_vld <= (r_state == ST_SCAN) && !cmp_hit && !cmp_end;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers of the sequencer.
    always_ff @(posedge i_clk) begin
        unique case (r_state) inside
            ST_IDLE: begin
                r_query <= in_query;
                r_idx   <= '0;
                r_seg   <= '0;
                if (in_op == OP_WRITE) begin
                    r_status <= STATUS_WRITE;
                end else if (n_use < COUNT_W'(2)) begin
                    r_status <= STATUS_FEW;
                end else begin
                    r_status <= STATUS_OK;
                end
                r_res_vec <= '0;
            end
            ST_SCAN: begin
                r_idx   <= r_idx + 1'b1;
                r_cmp_i <= r_idx;
                if (cmp_hit) begin
                    r_seg <= r_cmp_i;
                end else if (cmp_end) begin
                    r_seg    <= '0;
                    r_status <= STATUS_NONE;
                end
            end
            ST_RD_HI: begin
                r_t0 <= rd_time;
                r_v0 <= rd_vec;
            end
            ST_LATCH: begin
                r_t1 <= rd_time;
                r_v1 <= rd_vec;
                r_res_vec <= (n_use == COUNT_W'(1)) ? r_v0 : '0;
            end
            ST_FACTOR: begin
                r_factor <= q_lt_t0 ? '0 : FACTOR_ONE;
            end
            ST_DIV: begin
                if (div_done) begin
                    r_factor <= {1'b0, div_quot};
                end
            end
            ST_BLEND: begin
                if (lerp_done) begin
                    r_res_vec <= lerp_vec;
                end
            end
            ST_RD_LO, ST_DONE: begin
                r_idx <= r_idx;
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    // Output register holds the finished transaction until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {(M_DATA_W - VEC_W - SLOT_W)'(0), SLOT_W'(r_seg), r_res_vec};
            r_out_user <= r_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
